// ----- sv/assert_macros.svh -----
// Assertion macros shared by the duplicate remover RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SDR_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define SDR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SDR_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define SDR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/sdr_pkg.sv -----
// Shared types and constants of the stream duplicate remover.
// No dependencies; imported by the controller, datapath and top level.
package sdr_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned TotalW    = 9;
  localparam int unsigned OutTdataW = 48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic latch;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic term;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/sdr_ctrl.sv -----
// Controller of the duplicate remover: accept, scan, commit sequencing.
// Depends on sdr_pkg.
module sdr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  sdr_pkg::sts_t sts_i,
  output sdr_pkg::cmd_t cmd_o
);
  import sdr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.term) begin
          cmd_o.latch = 1'b1;
          state_d     = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // Wait here while the previous result still sits in the output register.
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/sdr_datapath.sv -----
// Datapath of the duplicate remover: value store, scan compare, counts, output register.
// Depends on sdr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sdr_datapath #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sdr_pkg::cmd_t                   cmd_i,
  output sdr_pkg::sts_t                   sts_o,
  input  logic [sdr_pkg::DataW-1:0]       s_tdata_i,
  input  logic                            s_tlast_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [sdr_pkg::OutTdataW-1:0]   m_tdata_o,
  output logic                            m_tlast_o
);
  import sdr_pkg::*;

  localparam int unsigned SW = (VALUE_BITS < DataW) ? VALUE_BITS : DataW;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [SW-1:0]     mem [DEPTH];
  logic [SW-1:0]     rd_data_q;
  logic [SW-1:0]     val_q;
  logic              last_q;
  logic [CW-1:0]     idx_q;
  logic              rd_vld_q;
  logic              found_q;
  logic [CW-1:0]     cnt_q;
  logic [TotalW-1:0] tot_q;
  logic [TotalW-1:0] tot_new;
  logic              hit;
  logic              at_end;
  logic              room;
  logic              wr_en;
  logic              out_vld_q;
  logic [SW-1:0]     out_val_q;
  logic              out_keep_q;
  logic [TotalW-1:0] out_tot_q;
  logic              out_ovf_q;
  logic              out_last_q;

  assign hit     = rd_vld_q && (rd_data_q == val_q);
  assign at_end  = (idx_q == cnt_q);
  assign room    = (cnt_q < CW'(DEPTH));
  assign wr_en   = cmd_i.commit && !found_q && room;
  assign tot_new = (found_q || (tot_q == '1)) ? tot_q : tot_q + TotalW'(1);

  assign sts_o.term     = hit || at_end;
  assign sts_o.out_free = !out_vld_q || m_tready_i;

  // Store: one read per scan cycle, one write at commit for a new value while room is left.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && !at_end) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q  <= s_tdata_i[SW-1:0];
      last_q <= s_tlast_i;
    end
    if (cmd_i.latch) begin
      found_q <= hit;
    end
    if (cmd_i.commit) begin
      out_val_q  <= val_q;
      out_keep_q <= !found_q;
      out_tot_q  <= tot_new;
      out_ovf_q  <= !found_q && !room;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      cnt_q     <= '0;
      tot_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.step) begin
        rd_vld_q <= !at_end;
        if (!at_end) begin
          idx_q <= idx_q + CW'(1);
        end
      end
      if (cmd_i.commit) begin
        // The last beat of a vector empties the store for the next one.
        if (last_q) begin
          cnt_q <= '0;
          tot_q <= '0;
        end else begin
          cnt_q <= wr_en ? cnt_q + CW'(1) : cnt_q;
          tot_q <= tot_new;
        end
      end
      if (cmd_i.commit) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {5'b0, out_ovf_q, out_tot_q, out_keep_q, DataW'(out_val_q)};

  `SDR_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH))
  `SDR_ASSERT_IMPL(a_commit_free, clk_i, rst_ni, cmd_i.commit, !out_vld_q || m_tready_i)
  `SDR_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, cmd_i.commit && last_q, cnt_q == '0 && tot_q == '0)
  `SDR_ASSERT_IMPL(a_ovf_keep, clk_i, rst_ni, out_vld_q && out_ovf_q, out_keep_q)

endmodule

// ----- sv/stream_duplicate_remover_core.sv -----
// Stream duplicate remover: flags the first occurrence of each value within a vector.
// A single result beat per input beat, tagged with keep, running distinct count and overflow.
// Slave channel s_axis: tdata carries the value, tlast marks the final beat of a vector.
// Master channel m_axis: tdata carries value_out, keep, unique_count, overflow; tlast
// copies the input marker.
// Each accepted beat is compared against the stored distinct values of the current
// vector, one store entry read per cycle from a single-port memory. With N values
// stored (at most DEPTH), the scan reads them in order and a match ends it early;
// the next beat is accepted only after the result of this one has been committed.
// A new value goes into the store at the next free entry; once DEPTH entries are held,
// further new values are kept but flagged with overflow. After the tlast beat the store
// and the counts start over.
// The result waits in an output register; the next beat is accepted while it waits,
// and the datapath holds its result until m_axis_tready_i frees the register.
// Reset empties the store and the counts and leaves both channels idle; no clearing
// pass is needed.
module stream_duplicate_remover_core #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [sdr_pkg::DataW-1:0]         s_axis_tdata_i,   // [31:0] value
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [31:0] value_out, [32] keep, [41:33] unique_count, [42] overflow, [47:43] zero
  output logic [sdr_pkg::OutTdataW-1:0]     m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import sdr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sdr_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule
